// File: rtl/bbs_pkg.sv
// Shared constants, types and helpers for the binary backtrack sequencer.
`default_nettype none

package bbs_pkg;

   // Longest solution and derived widths
   localparam int MAX_LEN    = 64;
   localparam int DEPTH_W    = $clog2(MAX_LEN + 1);
   localparam int POS_W      = $clog2(MAX_LEN);
   localparam int GROUP_W    = 8;
   localparam int NUM_GROUPS = MAX_LEN / GROUP_W;
   localparam int GIDX_W     = $clog2(NUM_GROUPS);
   localparam int BIDX_W     = $clog2(GROUP_W);

   // Stream payload widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = ((DEPTH_W + MAX_LEN + 2 + 7) / 8) * 8;

   // Command codes
   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_STEP    = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic eval;      // register the group occupancy flags
      logic commit;    // update the search state and the result
   } ctrl_cmd_type;

   // Index of the highest set bit of a group (0 when empty)
   function automatic logic [BIDX_W-1:0] hi_index_bit(input logic [GROUP_W-1:0] v);
      logic [BIDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < GROUP_W; i++) begin
         if (v[i]) begin
            idx = BIDX_W'(i);
         end
      end
      return idx;
   endfunction

   // Index of the highest set group flag (0 when empty)
   function automatic logic [GIDX_W-1:0] hi_index_grp(input logic [NUM_GROUPS-1:0] v);
      logic [GIDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         if (v[i]) begin
            idx = GIDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: rtl/binary_backtrack_sequencer.sv
// Binary backtrack sequencer: depth-first enumeration of 0/1 decision vectors.
// An accepted request is latched, the scan state registers the group flags
// ahead of the two-level priority encode on the decision vector, and the
// commit state updates the search state once the result slot is free.
// A response may wait in the output register while the next request is taken.
// Reset (synchronous, active high): depth 0, decisions clear, full_length 64.
`default_nettype none

module binary_backtrack_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: [0] cmd, [1] reject, rest zero
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bbs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response: [6:0] depth, [70:7] choice_bits, [71] exhausted, [72] complete
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bbs_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // full_length register write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bbs_pkg::DEPTH_W-1:0]       csr_data
);

   bbs_pkg::ctrl_cmd_type        cmd;
   logic [bbs_pkg::DEPTH_W-1:0]  out_depth;
   logic [bbs_pkg::MAX_LEN-1:0]  out_choice;
   logic                         out_exhausted;
   logic                         out_complete;

   assign csr_ready = 1'b1;

   bbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bbs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_cmd       (req_tdata[0]),
      .req_reject    (req_tdata[1]),
      .csr_we        (csr_valid && csr_ready),
      .csr_len       (csr_data),
      .out_depth     (out_depth),
      .out_choice    (out_choice),
      .out_exhausted (out_exhausted),
      .out_complete  (out_complete)
   );

   // Pack the response
   assign rsp_tdata = {
      {(bbs_pkg::RSP_DATA_W - bbs_pkg::DEPTH_W - bbs_pkg::MAX_LEN - 2){1'b0}},
      out_complete, out_exhausted, out_choice, out_depth
   };

   // Exhausted response carries no depth and no decisions
   a_exhausted_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_exhausted) |-> (out_depth == '0 && out_choice == '0))
      else $error("exhausted response with nonzero depth or decisions");

   // A complete candidate always has nonzero depth
   a_complete_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_complete) |-> (out_depth != '0))
      else $error("complete response at depth zero");

   // Decisions at and above the depth stay zero
   a_choice_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_choice >> out_depth) == '0))
      else $error("decision bits set at or above depth");

   // An accepted request occupies the scan cycle
   a_scan_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken during scan cycle");

endmodule

`default_nettype wire

// File: rtl/bbs_ctrl.sv
// Request sequencing controller for the binary backtrack sequencer.
`default_nettype none

module bbs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output bbs_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_commit;

   // Result slot is free or being drained this cycle
   assign can_commit = !rsp_valid_ff || rsp_tready;

   assign req_tready  = (state_ff == ST_IDLE) || ((state_ff == ST_COMMIT) && can_commit);
   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.eval    = (state_ff == ST_EVAL);
   assign cmd.commit  = (state_ff == ST_COMMIT) && can_commit;

   // Next state and result valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (can_commit) begin
               rsp_valid_in = 1'b1;
               state_in     = req_tvalid ? ST_EVAL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bbs_datapath.sv
// Decision vector, depth and backtrack search datapath.
`default_nettype none

module bbs_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bbs_pkg::ctrl_cmd_type           cmd,
   input  wire logic                            req_cmd,
   input  wire logic                            req_reject,
   input  wire logic                            csr_we,
   input  wire logic [bbs_pkg::DEPTH_W-1:0]     csr_len,
   output logic [bbs_pkg::DEPTH_W-1:0]          out_depth,
   output logic [bbs_pkg::MAX_LEN-1:0]          out_choice,
   output logic                                 out_exhausted,
   output logic                                 out_complete
);

   logic [bbs_pkg::MAX_LEN-1:0]    dec_ff, dec_in;
   logic [bbs_pkg::DEPTH_W-1:0]    depth_ff, depth_in;
   logic [bbs_pkg::DEPTH_W-1:0]    len_ff;
   logic                           cmd_ff, reject_ff;
   logic [bbs_pkg::NUM_GROUPS-1:0] grp_ff, grp_in;
   logic                           exh_ff, cmp_ff;

   logic [bbs_pkg::GIDX_W-1:0]     top_grp;
   logic [bbs_pkg::GROUP_W-1:0]    top_byte;
   logic [bbs_pkg::POS_W-1:0]      top_pos;
   logic [bbs_pkg::MAX_LEN-1:0]    keep_mask;

   // Group occupancy flags of the decision vector
   always_comb begin
      for (int g = 0; g < bbs_pkg::NUM_GROUPS; g++) begin
         grp_in[g] = |dec_ff[g*bbs_pkg::GROUP_W +: bbs_pkg::GROUP_W];
      end
   end

   // Deepest decision equal to one, from group flags then within the group
   assign top_grp   = bbs_pkg::hi_index_grp(grp_ff);
   assign top_byte  = dec_ff[top_grp*bbs_pkg::GROUP_W +: bbs_pkg::GROUP_W];
   assign top_pos   = {top_grp, bbs_pkg::hi_index_bit(top_byte)};
   assign keep_mask = (bbs_pkg::MAX_LEN'(1) << top_pos) - bbs_pkg::MAX_LEN'(1);

   // Restart, backtrack or extend
   always_comb begin
      if ((cmd_ff == bbs_pkg::CMD_RESTART) || (depth_ff == '0)) begin
         dec_in   = bbs_pkg::MAX_LEN'(1);
         depth_in = bbs_pkg::DEPTH_W'(1);
      end else if (reject_ff || (depth_ff >= len_ff)) begin
         if (|grp_ff) begin
            dec_in   = dec_ff & keep_mask;
            depth_in = {1'b0, top_pos} + bbs_pkg::DEPTH_W'(1);
         end else begin
            dec_in   = '0;
            depth_in = '0;
         end
      end else begin
         dec_in   = dec_ff | (bbs_pkg::MAX_LEN'(1) << depth_ff[bbs_pkg::POS_W-1:0]);
         depth_in = depth_ff + bbs_pkg::DEPTH_W'(1);
      end
   end

   // Search state and length register
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff   <= '0;
         depth_ff <= '0;
         len_ff   <= bbs_pkg::DEPTH_W'(bbs_pkg::MAX_LEN);
      end else begin
         if (cmd.commit) begin
            dec_ff   <= dec_in;
            depth_ff <= depth_in;
         end
         // zero means one, anything past the longest solution saturates
         if (csr_we) begin
            if (csr_len == '0) begin
               len_ff <= bbs_pkg::DEPTH_W'(1);
            end else if (csr_len > bbs_pkg::DEPTH_W'(bbs_pkg::MAX_LEN)) begin
               len_ff <= bbs_pkg::DEPTH_W'(bbs_pkg::MAX_LEN);
            end else begin
               len_ff <= csr_len;
            end
         end
      end
   end

   // Request latch, scan flags and result flags
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_cmd;
         reject_ff <= req_reject;
      end
      if (cmd.eval) begin
         grp_ff <= grp_in;
      end
      if (cmd.commit) begin
         exh_ff <= (depth_in == '0);
         cmp_ff <= (depth_in == len_ff);
      end
   end

   assign out_depth     = depth_ff;
   assign out_choice    = dec_ff;
   assign out_exhausted = exh_ff;
   assign out_complete  = cmp_ff;

endmodule

`default_nettype wire
